// ----- rtl/core/dopt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dopt_pkg
// Shared types, option codes and helpers for the DHCP options TLV parser.
// ----------------------------------------------------------------------------
package dopt_pkg;

  localparam int unsigned FOUND_W = 5;

  // Option codes that the parser handles.
  localparam logic [7:0] CODE_PAD         = 8'd0;
  localparam logic [7:0] CODE_SUBNET_MASK = 8'd1;
  localparam logic [7:0] CODE_ROUTER      = 8'd3;
  localparam logic [7:0] CODE_MSG_TYPE    = 8'd53;
  localparam logic [7:0] CODE_SERVER_ID   = 8'd54;
  localparam logic [7:0] CODE_RENEWAL     = 8'd58;
  localparam logic [7:0] CODE_END         = 8'd255;

  // Bit positions in the found flags.
  localparam int unsigned FOUND_TYPE    = 0;
  localparam int unsigned FOUND_SERVER  = 1;
  localparam int unsigned FOUND_ROUTER  = 2;
  localparam int unsigned FOUND_MASK    = 3;
  localparam int unsigned FOUND_RENEWAL = 4;

  // Value bytes captured for each option kind.
  localparam logic [2:0] NEED_NONE = 3'd0;
  localparam logic [2:0] NEED_BYTE = 3'd1;
  localparam logic [2:0] NEED_WORD = 3'd4;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]         msg_type;
    logic [31:0]        server_ip;
    logic [31:0]        router_ip;
    logic [31:0]        subnet_mask;
    logic [31:0]        renewal_seconds;
    logic [FOUND_W-1:0] found_flags;
    logic               truncated;
  } out_t;

  // Handshake between the input register and the parse stage.
  typedef struct packed {
    logic step;
    logic emit;
  } step_ctl_t;

  function automatic logic [2:0] needed_bytes(input logic [7:0] code);
    logic [2:0] need;
    unique case (code)
      CODE_MSG_TYPE: need = NEED_BYTE;
      CODE_SERVER_ID, CODE_ROUTER, CODE_SUBNET_MASK, CODE_RENEWAL: need = NEED_WORD;
      default: need = NEED_NONE;
    endcase
    return need;
  endfunction

endpackage

// ----- rtl/core/dopt_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dopt_in_stage
// Input register: holds one options byte until the parse stage consumes it.
// ----------------------------------------------------------------------------
module dopt_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dopt_pkg::in_t in_data_i,
  input  logic          step_i,
  output logic          hold_valid_o,
  output dopt_pkg::in_t hold_data_o
);

  logic          valid_q, valid_d;
  dopt_pkg::in_t data_q;

  // The register frees up in the same cycle its byte is consumed.
  assign in_ready_o = !valid_q || step_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !step_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_data_o  = data_q;

endmodule

// ----- rtl/core/dopt_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dopt_parse
// Option walker: code, length and value phases, capture and commit of the
// selected options, and assembly of the per-packet result.
// ----------------------------------------------------------------------------
module dopt_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  dopt_pkg::in_t  item_i,
  output logic           emit_o,
  output dopt_pkg::out_t result_o
);

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN,
    PH_VALUE,
    PH_DRAIN
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [7:0]                   code_q, code_d;
  logic [7:0]                   left_q, left_d;
  logic [31:0]                  cap_q, cap_d;
  logic [2:0]                   taken_q, taken_d;
  logic [7:0]                   type_q, type_d;
  logic [31:0]                  server_q, server_d;
  logic [31:0]                  router_q, router_d;
  logic [31:0]                  mask_q, mask_d;
  logic [31:0]                  renew_q, renew_d;
  logic [dopt_pkg::FOUND_W-1:0] found_q, found_d;

  logic       emit, trunc, clear, go_drain;
  logic [2:0] need;
  logic [7:0] b;
  logic       last;

  assign b    = item_i.option_byte;
  assign last = item_i.last_byte;
  assign need = dopt_pkg::needed_bytes(code_q);

  always_comb begin
    phase_d  = phase_q;
    code_d   = code_q;
    left_d   = left_q;
    cap_d    = cap_q;
    taken_d  = taken_q;
    type_d   = type_q;
    server_d = server_q;
    router_d = router_q;
    mask_d   = mask_q;
    renew_d  = renew_q;
    found_d  = found_q;
    emit     = 1'b0;
    trunc    = 1'b0;
    clear    = 1'b0;
    go_drain = 1'b0;

    unique case (phase_q)
      PH_CODE: begin
        if (b == dopt_pkg::CODE_PAD) begin
          emit = last;
        end else if (b == dopt_pkg::CODE_END) begin
          emit     = 1'b1;
          go_drain = !last;
        end else begin
          code_d = b;
          if (last) begin
            emit  = 1'b1;
            trunc = 1'b1;
          end else begin
            phase_d = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        left_d  = b;
        cap_d   = '0;
        taken_d = '0;
        if (b == 8'd0) begin
          phase_d = PH_CODE;
          emit    = last;
        end else if (last) begin
          emit  = 1'b1;
          trunc = 1'b1;
        end else begin
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (taken_q < need) begin
          cap_d   = {cap_q[23:0], b};
          taken_d = taken_q + 3'd1;
        end
        left_d = left_q - 8'd1;
        if (left_d == 8'd0) begin
          // Commit only an option whose value arrived in full.
          if (need != dopt_pkg::NEED_NONE && taken_d == need) begin
            unique case (code_q)
              dopt_pkg::CODE_MSG_TYPE: begin
                type_d = cap_d[7:0];
                found_d[dopt_pkg::FOUND_TYPE] = 1'b1;
              end
              dopt_pkg::CODE_SERVER_ID: begin
                server_d = cap_d;
                found_d[dopt_pkg::FOUND_SERVER] = 1'b1;
              end
              dopt_pkg::CODE_ROUTER: begin
                router_d = cap_d;
                found_d[dopt_pkg::FOUND_ROUTER] = 1'b1;
              end
              dopt_pkg::CODE_SUBNET_MASK: begin
                mask_d = cap_d;
                found_d[dopt_pkg::FOUND_MASK] = 1'b1;
              end
              dopt_pkg::CODE_RENEWAL: begin
                renew_d = cap_d;
                found_d[dopt_pkg::FOUND_RENEWAL] = 1'b1;
              end
              default: begin
              end
            endcase
          end
          phase_d = PH_CODE;
          emit    = last;
        end else if (last) begin
          emit  = 1'b1;
          trunc = 1'b1;
        end
      end
      PH_DRAIN: begin
        clear = last;
      end
      default: begin
      end
    endcase

    // The result reflects the packet after any commit on this byte.
    result_o.msg_type        = type_d;
    result_o.server_ip       = server_d;
    result_o.router_ip       = router_d;
    result_o.subnet_mask     = mask_d;
    result_o.renewal_seconds = renew_d;
    result_o.found_flags     = found_d;
    result_o.truncated       = trunc;

    // Every result, and every last byte, starts a fresh packet.
    if (emit || clear) begin
      phase_d  = go_drain ? PH_DRAIN : PH_CODE;
      code_d   = '0;
      left_d   = '0;
      cap_d    = '0;
      taken_d  = '0;
      type_d   = '0;
      server_d = '0;
      router_d = '0;
      mask_d   = '0;
      renew_d  = '0;
      found_d  = '0;
    end
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CODE;
      code_q   <= '0;
      left_q   <= '0;
      cap_q    <= '0;
      taken_q  <= '0;
      type_q   <= '0;
      server_q <= '0;
      router_q <= '0;
      mask_q   <= '0;
      renew_q  <= '0;
      found_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      code_q   <= code_d;
      left_q   <= left_d;
      cap_q    <= cap_d;
      taken_q  <= taken_d;
      type_q   <= type_d;
      server_q <= server_d;
      router_q <= router_d;
      mask_q   <= mask_d;
      renew_q  <= renew_d;
      found_q  <= found_d;
    end
  end

endmodule

// ----- rtl/core/dhcp_option_tlv_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser_top
// Result path: a packet's End or last byte is accepted into the input register,
//   and its result is then loaded into the result register and offered.
// Throughput: one options byte per cycle; a waiting result stalls input only
//   when the next byte would itself produce a result.
// Reset: asynchronous, active low; clears all parse state and both valids.
// ----------------------------------------------------------------------------
module dhcp_option_tlv_parser_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dopt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dopt_pkg::out_t out_data_o
);

  logic               hold_valid;
  dopt_pkg::in_t      hold_data;
  dopt_pkg::step_ctl_t ctl;
  dopt_pkg::out_t     result;
  logic               out_free;

  logic               out_valid_q, out_valid_d;
  dopt_pkg::out_t     out_q;

  // The input register feeds the parser one byte per cycle unless stalled.
  dopt_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .step_i       (ctl.step),
    .hold_valid_o (hold_valid),
    .hold_data_o  (hold_data)
  );

  // The parse stage works on the held byte combinationally and updates its
  // state only when the step is taken.
  dopt_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (ctl.step),
    .item_i   (hold_data),
    .emit_o   (ctl.emit),
    .result_o (result)
  );

  // A byte that yields no result may always advance. A byte that closes a
  // packet needs the result register to be empty or emptying this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  assign ctl.step = hold_valid && (!ctl.emit || out_free);

  assign out_valid_d = (ctl.step && ctl.emit) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.step && ctl.emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A closing byte that steps always leaves a result on offer.
  a_emit_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.step && ctl.emit) |=> out_valid_q)
    else $error("result transaction lost after a closing byte");

  // A result that is not taken is never overwritten by a new one.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(ctl.step && ctl.emit))
    else $error("pending result overwritten");

  // A held byte stays held until the parse stage consumes it.
  a_hold_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid && !ctl.step) |=> hold_valid)
    else $error("input byte dropped before parsing");

  // Message type is zero whenever it was not found in the packet.
  a_type_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.found_flags[dopt_pkg::FOUND_TYPE] || out_q.msg_type == 8'd0))
    else $error("message type set without its found flag");

endmodule
